### rtl/core/density_intersection_distance_defines.svh
// Assertion helpers used by the checker module of this block.
`ifndef DENSITY_INTERSECTION_DISTANCE_DEFINES_SVH
`define DENSITY_INTERSECTION_DISTANCE_DEFINES_SVH

// Checked only while the block is out of reset.
`define DID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define DID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/did_pkg.sv
package did_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int CELL_W  = 8;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = CELL_W + SCALE_W;
  localparam int DIST_W  = 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from the word address.
  localparam logic REG_NA_CODE = 1'b0;

  localparam logic [DIST_W-1:0] NA_CODE_RST = 8'hFF;

  // One cell's contribution as it leaves the product stage.
  typedef struct packed {
    logic [PROD_W-1:0] lo;
    logic              missing;
    logic              last;
  } prod_t;

endpackage

### rtl/core/did_prod.sv
module did_prod import did_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CELL_W-1:0]  in_cell_a,
  input  logic [CELL_W-1:0]  in_cell_b,
  input  logic [SCALE_W-1:0] in_scale_a,
  input  logic [SCALE_W-1:0] in_scale_b,
  input  logic              in_missing_a,
  input  logic              in_missing_b,
  input  logic              in_last_cell,
  input  logic              down_rdy,
  output logic              prod_vld,
  output prod_t             prod
);

  logic               in_vld_r;
  logic [CELL_W-1:0]  cell_a_r;
  logic [CELL_W-1:0]  cell_b_r;
  logic [SCALE_W-1:0] scale_a_r;
  logic [SCALE_W-1:0] scale_b_r;
  logic               missing_r;
  logic               last_r;
  logic               prod_vld_r;
  prod_t              prod_r;
  prod_t              prod_nxt;
  logic               prod_rdy;
  logic               in_rdy;
  logic [PROD_W-1:0]  pa;
  logic [PROD_W-1:0]  pb;

  // Each stage moves on when it is empty or its content moves on too.
  assign prod_rdy = !prod_vld_r || down_rdy;
  assign in_rdy   = !in_vld_r || prod_rdy;
  assign in_stall = !in_rdy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_valid) begin
      cell_a_r  <= in_cell_a;
      cell_b_r  <= in_cell_b;
      scale_a_r <= in_scale_a;
      scale_b_r <= in_scale_b;
      missing_r <= in_missing_a | in_missing_b;
      last_r    <= in_last_cell;
    end
  end

  // Both scaled cells, then the smaller of the two.
  always_comb begin
    pa = PROD_W'(cell_a_r) * PROD_W'(scale_a_r);
    pb = PROD_W'(cell_b_r) * PROD_W'(scale_b_r);
    prod_nxt.lo      = (pa < pb) ? pa : pb;
    prod_nxt.missing = missing_r;
    prod_nxt.last    = last_r;
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (prod_rdy) begin
      prod_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_rdy && in_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_vld = prod_vld_r;
  assign prod     = prod_r;

endmodule

### rtl/core/did_acc.sv
module did_acc import did_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       prod_vld,
  input  prod_t                      prod,
  output logic                       acc_rdy,
  input  logic                       down_rdy,
  output logic                       fin_vld,
  output logic [SCALE_FRAC_BITS+7:0] fin_sum,
  output logic                       fin_missing
);

  localparam int ACC_W = SCALE_FRAC_BITS + 8;
  localparam int SUM_W = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
  localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_W{1'b1}});

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             seen_r;
  logic             seen_nxt;
  logic             fin_vld_r;
  logic [ACC_W-1:0] fin_sum_r;
  logic             fin_missing_r;
  logic [SUM_W-1:0] sum;
  logic             take;

  assign acc_rdy = !fin_vld_r || down_rdy;
  assign take    = prod_vld && acc_rdy;

  // Saturating add of this cell's overlap.
  always_comb begin
    sum      = SUM_W'(acc_r) + SUM_W'(prod.lo);
    acc_nxt  = (sum > ACC_MAX) ? {ACC_W{1'b1}} : ACC_W'(sum);
    seen_nxt = seen_r | prod.missing;
  end

  // Running state; a last cell hands the pair over and clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      seen_r <= 1'b0;
    end else if (take) begin
      if (prod.last) begin
        acc_r  <= '0;
        seen_r <= 1'b0;
      end else begin
        acc_r  <= acc_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // Finished pair waiting for the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (acc_rdy) begin
      fin_vld_r <= prod_vld && prod.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && prod.last) begin
      fin_sum_r     <= acc_nxt;
      fin_missing_r <= seen_nxt;
    end
  end

  assign fin_vld     = fin_vld_r;
  assign fin_sum     = fin_sum_r;
  assign fin_missing = fin_missing_r;

endmodule

### rtl/core/did_res.sv
module did_res import did_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fin_vld,
  input  logic [SCALE_FRAC_BITS+7:0] fin_sum,
  input  logic                       fin_missing,
  input  logic [DIST_W-1:0]          na_code,
  output logic                       res_rdy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DIST_W-1:0]          out_distance,
  output logic                       out_is_na
);

  localparam int ACC_W  = SCALE_FRAC_BITS + 8;
  localparam int DIFF_W = SCALE_FRAC_BITS + 1;
  localparam int MUL_W  = DIFF_W + 8;
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << SCALE_FRAC_BITS;

  logic [ACC_W-1:0]  clamped;
  logic [DIFF_W-1:0] diff;
  logic [MUL_W-1:0]  diff255;
  logic [DIST_W-1:0] dist_nxt;
  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic              is_na_r;

  assign res_rdy = !out_valid_r || !out_stall;

  // Clamp to one, then floor((1 - sum) * 255) with 255x as a shift and subtract.
  always_comb begin
    clamped  = (fin_sum > ACC_ONE) ? ACC_ONE : fin_sum;
    diff     = DIFF_W'(ACC_ONE) - DIFF_W'(clamped);
    diff255  = {diff, 8'b0} - MUL_W'(diff);
    dist_nxt = fin_missing ? na_code : diff255[SCALE_FRAC_BITS +: DIST_W];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && fin_vld) begin
      dist_r  <= dist_nxt;
      is_na_r <= fin_missing;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;
  assign out_is_na    = is_na_r;

endmodule

### rtl/core/density_intersection_distance.sv
// Histogram intersection distance between two quantized densities.
// Input channel: one transaction per grid cell carries both cell bytes, both
// Q0.32 scales, both missing flags and a last_cell marker; in_valid/in_stall.
// Result channel: one transaction per pair, sent for the cell marked last,
// with the distance byte and is_na; out_valid/out_stall.
// Configuration: APB-style port with one register, na_code at address 0.
// Throughput is one cell per cycle while the result side does not stall:
// the products, the minimum and the saturating add of the accumulator are
// one pipeline step each cell. The last cell passes the input register,
// product register, accumulator and result register on its way to out_valid.
// Reset clears all valid bits, the accumulator and the missing flag, and sets
// na_code to 255; no clearing pass is needed, so cells are taken at once.
// A stall on the result side holds the result; cells keep entering until the
// four stage registers are full, and then in_stall rises in the same cycle.
module density_intersection_distance import did_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CELL_W-1:0]     in_cell_a,
  input  logic [CELL_W-1:0]     in_cell_b,
  input  logic [SCALE_W-1:0]    in_scale_a,
  input  logic [SCALE_W-1:0]    in_scale_b,
  input  logic                  in_missing_a,
  input  logic                  in_missing_b,
  input  logic                  in_last_cell,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIST_W-1:0]     out_distance,
  output logic                  out_is_na,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DIST_W-1:0]          na_code_r;
  logic                       cfg_wr;
  logic                       reg_idx;
  logic                       prod_vld;
  prod_t                      prod;
  logic                       acc_rdy;
  logic                       fin_vld;
  logic [SCALE_FRAC_BITS+7:0] fin_sum;
  logic                       fin_missing;
  logic                       res_rdy;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_code_r <= NA_CODE_RST;
    end else if (cfg_wr && (reg_idx == REG_NA_CODE)) begin
      na_code_r <= pwdata[DIST_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_NA_CODE) ? CFG_DATA_W'(na_code_r) : '0;

  // Input and product stages.
  did_prod u_prod (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_a    (in_cell_a),
    .in_cell_b    (in_cell_b),
    .in_scale_a   (in_scale_a),
    .in_scale_b   (in_scale_b),
    .in_missing_a (in_missing_a),
    .in_missing_b (in_missing_b),
    .in_last_cell (in_last_cell),
    .down_rdy     (acc_rdy),
    .prod_vld     (prod_vld),
    .prod         (prod)
  );

  // Accumulator.
  did_acc #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .prod_vld    (prod_vld),
    .prod        (prod),
    .acc_rdy     (acc_rdy),
    .down_rdy    (res_rdy),
    .fin_vld     (fin_vld),
    .fin_sum     (fin_sum),
    .fin_missing (fin_missing)
  );

  // Distance and result register.
  did_res #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_res (
    .clk          (clk),
    .rst_n        (rst_n),
    .fin_vld      (fin_vld),
    .fin_sum      (fin_sum),
    .fin_missing  (fin_missing),
    .na_code      (na_code_r),
    .res_rdy      (res_rdy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_is_na    (out_is_na)
  );

endmodule

### rtl/core/density_intersection_distance_chk.sv
`include "density_intersection_distance_defines.svh"

module density_intersection_distance_chk import did_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DIST_W-1:0]     out_distance,
  input logic                  out_is_na,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata,
  input logic                  pready
);

  // Reset empties the pipeline: nothing to send, room for cells.
  `DID_ASSERT_ALWAYS(a_rst_out_empty, !rst_n |=> !out_valid, "result valid after reset")
  `DID_ASSERT_ALWAYS(a_rst_in_open, !rst_n |=> !in_stall, "input stalled after reset")

  // Back pressure only comes from a held result, through a full pipeline.
  `DID_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stall without output stall")

  // A held result transaction keeps its payload.
  `DID_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_distance) && $stable(out_is_na)), "stalled result changed")

  // A write of the NA code reads back.
  `DID_ASSERT(a_na_readback, (psel && penable && pwrite && pready && !paddr[2]) |=> (paddr[2] || (prdata[DIST_W-1:0] == $past(pwdata[DIST_W-1:0]))), "NA code readback mismatch")

endmodule

bind density_intersection_distance density_intersection_distance_chk u_chk (.*);
